// ===== hdl/pidcd_pkg.sv =====
// Shared types and constants for the PID step with clamp and deadband.
package pidcd_pkg;

    localparam int ERROR_WIDTH_DEF = 16;
    localparam int GAIN_FRAC_DEF   = 8;

    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 32;
    localparam int TOL_W   = 16;
    localparam int DRIVE_W = 32;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_IUPPER = 3'd3;
    localparam logic [2:0] REG_ILOWER = 3'd4;
    localparam logic [2:0] REG_TOL    = 3'd5;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic signed [INTEG_W-1:0] upper;
        logic signed [INTEG_W-1:0] lower;
        logic        [TOL_W-1:0]   tol;
    } t_cfg;

endpackage

// ===== hdl/pidcd_regs.sv =====
// Configuration register file behind the APB-style port.
module pidcd_regs
    import pidcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic c_wr;
    logic [2:0] c_idx;

    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite;
    assign c_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (c_wr) begin
            case (c_idx)
                REG_KP:     r_cfg.kp    <= pwdata[GAIN_W-1:0];
                REG_KI:     r_cfg.ki    <= pwdata[GAIN_W-1:0];
                REG_KD:     r_cfg.kd    <= pwdata[GAIN_W-1:0];
                REG_IUPPER: r_cfg.upper <= pwdata[INTEG_W-1:0];
                REG_ILOWER: r_cfg.lower <= pwdata[INTEG_W-1:0];
                REG_TOL:    r_cfg.tol   <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (c_idx)
            REG_KP:     prdata = CFG_DW'($unsigned(r_cfg.kp));
            REG_KI:     prdata = CFG_DW'($unsigned(r_cfg.ki));
            REG_KD:     prdata = CFG_DW'($unsigned(r_cfg.kd));
            REG_IUPPER: prdata = CFG_DW'($unsigned(r_cfg.upper));
            REG_ILOWER: prdata = CFG_DW'($unsigned(r_cfg.lower));
            REG_TOL:    prdata = CFG_DW'(r_cfg.tol);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hdl/pidcd_front.sv =====
// Input register, integral and previous-error state, and the derivative stage.
module pidcd_front
    import pidcd_pkg::*;
#(
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    input  logic signed [ERROR_WIDTH-1:0] i_error,
    input  logic                          i_restart,
    output logic                          o_stall,
    input  logic                          i_next_ready,
    output logic                          o_s2_vld,
    output logic signed [ERROR_WIDTH-1:0] o_s2_err,
    output logic signed [INTEG_W-1:0]     o_s2_sum,
    output logic signed [ERROR_WIDTH:0]   o_s2_deriv,
    output logic                          o_s2_within
);

    localparam int SUM_W = INTEG_W + 2;
    localparam int MAG_W = ERROR_WIDTH + 1;
    localparam int CMP_W = ERROR_WIDTH + TOL_W + 1;

    logic                          r_s1_vld;
    logic signed [ERROR_WIDTH-1:0] r_s1_err;
    logic                          r_s1_rst;
    logic signed [INTEG_W-1:0]     r_integ;
    logic signed [ERROR_WIDTH-1:0] r_prev;
    logic                          r_s2_vld;
    logic signed [ERROR_WIDTH-1:0] r_s2_err;
    logic signed [INTEG_W-1:0]     r_s2_sum;
    logic signed [ERROR_WIDTH:0]   r_s2_deriv;
    logic                          r_s2_within;

    logic                          c_s1_ready;
    logic                          c_s2_ready;
    logic signed [INTEG_W-1:0]     c_base_i;
    logic signed [ERROR_WIDTH-1:0] c_base_p;
    logic signed [SUM_W-1:0]       c_sum_w;
    logic signed [INTEG_W-1:0]     c_sum_sat;
    logic signed [INTEG_W-1:0]     c_sum_clamp;
    logic signed [MAG_W-1:0]       c_err_x;
    logic        [MAG_W-1:0]       c_mag;
    logic                          c_within;
    logic signed [INTEG_W-1:0]     n_integ;
    logic signed [ERROR_WIDTH:0]   c_deriv;

    assign c_s2_ready = !r_s2_vld || i_next_ready;
    assign c_s1_ready = !r_s1_vld || c_s2_ready;
    assign o_stall    = !c_s1_ready;

    always_comb begin
        c_base_i = r_s1_rst ? '0 : r_integ;
        c_base_p = r_s1_rst ? '0 : r_prev;

        // Saturating add: the top bits must all agree for the sum to fit.
        c_sum_w = SUM_W'(c_base_i) + SUM_W'(r_s1_err);
        if ((&c_sum_w[SUM_W-1:INTEG_W-1]) || !(|c_sum_w[SUM_W-1:INTEG_W-1])) begin
            c_sum_sat = c_sum_w[INTEG_W-1:0];
        end else if (c_sum_w[SUM_W-1]) begin
            c_sum_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            c_sum_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        end

        // With crossed bounds, a sum below lower gives lower, else upper.
        if (c_sum_sat < i_cfg.lower) begin
            c_sum_clamp = i_cfg.lower;
        end else if (c_sum_sat > i_cfg.upper) begin
            c_sum_clamp = i_cfg.upper;
        end else begin
            c_sum_clamp = c_sum_sat;
        end

        c_err_x  = MAG_W'(r_s1_err);
        c_mag    = r_s1_err[ERROR_WIDTH-1] ? $unsigned(-c_err_x) : $unsigned(c_err_x);
        c_within = CMP_W'(c_mag) < CMP_W'(i_cfg.tol);
        n_integ  = c_within ? '0 : c_sum_clamp;
        c_deriv  = MAG_W'(r_s1_err) - MAG_W'(c_base_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_integ  <= '0;
            r_prev   <= '0;
        end else begin
            if (c_s1_ready) begin
                r_s1_vld <= i_valid;
            end
            if (c_s2_ready) begin
                r_s2_vld <= r_s1_vld;
            end
            if (r_s1_vld && c_s2_ready) begin
                r_integ <= n_integ;
                r_prev  <= r_s1_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && c_s1_ready) begin
            r_s1_err <= i_error;
            r_s1_rst <= i_restart;
        end
        if (r_s1_vld && c_s2_ready) begin
            r_s2_err    <= r_s1_err;
            r_s2_sum    <= n_integ;
            r_s2_deriv  <= c_deriv;
            r_s2_within <= c_within;
        end
    end

    assign o_s2_vld    = r_s2_vld;
    assign o_s2_err    = r_s2_err;
    assign o_s2_sum    = r_s2_sum;
    assign o_s2_deriv  = r_s2_deriv;
    assign o_s2_within = r_s2_within;

endmodule

// ===== hdl/pidcd_back.sv =====
// Gain multiplies, accumulation, scaling with saturation, and the result register.
module pidcd_back
    import pidcd_pkg::*;
#(
    parameter int ERROR_WIDTH    = ERROR_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_s2_vld,
    input  logic signed [ERROR_WIDTH-1:0] i_s2_err,
    input  logic signed [INTEG_W-1:0]     i_s2_sum,
    input  logic signed [ERROR_WIDTH:0]   i_s2_deriv,
    input  logic                          i_s2_within,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DRIVE_W-1:0]     o_drive,
    output logic                          o_within_tolerance
);

    localparam int PROP_W = GAIN_W + ERROR_WIDTH;
    localparam int INT_W  = GAIN_W + INTEG_W;
    localparam int DER_W  = GAIN_W + ERROR_WIDTH + 1;
    localparam int MAXP_W = (INT_W > DER_W) ? INT_W : DER_W;
    localparam int ACC_W  = MAXP_W + 2;

    logic                     r_p_vld;
    logic signed [PROP_W-1:0] r_p_prop;
    logic signed [INT_W-1:0]  r_p_int;
    logic signed [DER_W-1:0]  r_p_der;
    logic                     r_p_within;
    logic                     r_a_vld;
    logic signed [ACC_W-1:0]  r_a_acc;
    logic                     r_a_within;
    logic                     r_o_vld;
    logic signed [DRIVE_W-1:0] r_o_drive;
    logic                     r_o_within;

    logic                     c_o_ready;
    logic                     c_a_ready;
    logic                     c_p_ready;
    logic signed [ACC_W-1:0]  c_bias;
    logic signed [ACC_W-1:0]  c_q;
    logic signed [DRIVE_W-1:0] n_drive;

    assign c_o_ready = !r_o_vld || !i_stall;
    assign c_a_ready = !r_a_vld || c_o_ready;
    assign c_p_ready = !r_p_vld || c_a_ready;
    assign o_ready   = c_p_ready;

    always_comb begin
        // Bias negative values so the shift truncates toward zero.
        c_bias = r_a_acc[ACC_W-1] ?
            ACC_W'((65'd1 << GAIN_FRAC_BITS) - 65'd1) : '0;
        c_q = (r_a_acc + c_bias) >>> GAIN_FRAC_BITS;
        if (r_a_within) begin
            n_drive = '0;
        end else if ((&c_q[ACC_W-1:DRIVE_W-1]) || !(|c_q[ACC_W-1:DRIVE_W-1])) begin
            n_drive = c_q[DRIVE_W-1:0];
        end else if (c_q[ACC_W-1]) begin
            n_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            n_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (c_p_ready) begin
                r_p_vld <= i_s2_vld;
            end
            if (c_a_ready) begin
                r_a_vld <= r_p_vld;
            end
            if (c_o_ready) begin
                r_o_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s2_vld && c_p_ready) begin
            r_p_prop   <= PROP_W'(i_cfg.kp) * PROP_W'(i_s2_err);
            r_p_int    <= INT_W'(i_cfg.ki) * INT_W'(i_s2_sum);
            r_p_der    <= DER_W'(i_cfg.kd) * DER_W'(i_s2_deriv);
            r_p_within <= i_s2_within;
        end
        if (r_p_vld && c_a_ready) begin
            r_a_acc    <= ACC_W'(r_p_prop) + ACC_W'(r_p_int) + ACC_W'(r_p_der);
            r_a_within <= r_p_within;
        end
        if (r_a_vld && c_o_ready) begin
            r_o_drive  <= n_drive;
            r_o_within <= r_a_within;
        end
    end

    assign o_valid            = r_o_vld;
    assign o_drive            = r_o_drive;
    assign o_within_tolerance = r_o_within;

endmodule

// ===== hdl/pid_step_with_clamp_deadband.sv =====
// Top level of the PID step with anti-windup clamp and tolerance deadband.
//
// Each request carries one signed error sample and a restart flag; each
// produces exactly one result with the saturated drive and a flag telling
// whether the error magnitude was below the tolerance.
// Both channels use valid and stall: a request is taken on an edge with
// valid high and stall low. Gains, integral bounds and tolerance are
// written through the APB-style port, by the user only while no request is
// in flight; the block does not enforce this. A request goes from the
// accepting edge to o_valid through the input register, the integral
// stage and the multiply, accumulate and result registers. One request
// is accepted per cycle while nothing stalls; the integral update is
// registered in the integral stage. A receiver stall holds the result
// register; the stages in front keep filling any empty slots, so requests
// are still taken until the pipeline is full. Reset clears the config
// registers, the integral and the previous error, and empties the pipeline.
module pid_step_with_clamp_deadband
    import pidcd_pkg::*;
#(
    parameter int ERROR_WIDTH    = ERROR_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_AW-1:0]             paddr,
    input  logic [CFG_DW-1:0]             pwdata,
    output logic [CFG_DW-1:0]             prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ERROR_WIDTH-1:0] i_error,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DRIVE_W-1:0]     o_drive,
    output logic                          o_within_tolerance
);

    t_cfg                          w_cfg;
    logic                          w_back_ready;
    logic                          w_s2_vld;
    logic signed [ERROR_WIDTH-1:0] w_s2_err;
    logic signed [INTEG_W-1:0]     w_s2_sum;
    logic signed [ERROR_WIDTH:0]   w_s2_deriv;
    logic                          w_s2_within;

    pidcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidcd_front #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .i_error      (i_error),
        .i_restart    (i_restart),
        .o_stall      (o_stall),
        .i_next_ready (w_back_ready),
        .o_s2_vld     (w_s2_vld),
        .o_s2_err     (w_s2_err),
        .o_s2_sum     (w_s2_sum),
        .o_s2_deriv   (w_s2_deriv),
        .o_s2_within  (w_s2_within)
    );

    pidcd_back #(
        .ERROR_WIDTH    (ERROR_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_s2_vld           (w_s2_vld),
        .i_s2_err           (w_s2_err),
        .i_s2_sum           (w_s2_sum),
        .i_s2_deriv         (w_s2_deriv),
        .i_s2_within        (w_s2_within),
        .o_ready            (w_back_ready),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive            (o_drive),
        .o_within_tolerance (o_within_tolerance)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PID step with anti-windup clamp and deadband.
module testbench;
    import pidcd_pkg::*;

    // Decoded indexes past the last register; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int NUM_REGS       = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 100;

    localparam logic signed [INTEG_W-1:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic signed [INTEG_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;

    typedef struct {
        logic signed [ERROR_WIDTH_DEF-1:0] err;
        logic                              restart;
        logic                              drain_first;
    } t_request;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      in_band;
    } t_drive_result;

    logic                              i_clk     = 1'b0;
    logic                              i_rst_n   = 1'b0;
    logic                              psel      = 1'b0;
    logic                              penable   = 1'b0;
    logic                              pwrite    = 1'b0;
    logic [CFG_AW-1:0]                 paddr     = '0;
    logic [CFG_DW-1:0]                 pwdata    = '0;
    logic [CFG_DW-1:0]                 prdata;
    logic                              pready;
    logic                              i_valid   = 1'b0;
    logic                              o_stall;
    logic signed [ERROR_WIDTH_DEF-1:0] i_error   = '0;
    logic                              i_restart = 1'b0;
    logic                              o_valid;
    logic                              i_stall   = 1'b0;
    logic signed [DRIVE_W-1:0]         o_drive;
    logic                              o_within_tolerance;

    t_request      pending_requests[$];
    t_drive_result expected_drives[$];
    t_request      on_bus;
    t_drive_result oldest;

    logic [CFG_DW-1:0]                 reg_shadow[NUM_REGS];
    logic signed [INTEG_W-1:0]         integ_state = '0;
    logic signed [ERROR_WIDTH_DEF-1:0] last_error  = '0;

    t_idle_mode gap_mode   = IDLE_NONE;
    t_idle_mode stall_mode = IDLE_NONE;
    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int failures    = 0;
    int n_requests  = 0;
    int n_restarts  = 0;
    int n_within    = 0;
    int n_settings  = 0;

    always #5 i_clk = ~i_clk;

    pid_step_with_clamp_deadband uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_error            (i_error),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_drive            (o_drive),
        .o_within_tolerance (o_within_tolerance)
    );

    function automatic longint clip32(input longint v);
        if (v > longint'(INT_MAX)) return longint'(INT_MAX);
        if (v < longint'(INT_MIN)) return longint'(INT_MIN);
        return v;
    endfunction

    function automatic logic [CFG_DW-1:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_IUPPER, REG_ILOWER: return 32'hffff_ffff;
            default: return 32'h0000_ffff;
        endcase
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
        if (idx <= REG_TOL)
            reg_shadow[idx] = val & reg_mask(idx);
    endfunction

    // One controller step: integral update with saturation, clamp and deadband,
    // then the Q8.8 weighted sum truncated toward zero and saturated.
    function automatic t_drive_result control_step(input t_request rq);
        t_drive_result             res;
        longint                    e;
        longint                    s;
        longint                    d;
        longint                    acc;
        longint                    mag;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic signed [INTEG_W-1:0] upper;
        logic signed [INTEG_W-1:0] lower;
        kp    = reg_shadow[REG_KP][GAIN_W-1:0];
        ki    = reg_shadow[REG_KI][GAIN_W-1:0];
        kd    = reg_shadow[REG_KD][GAIN_W-1:0];
        upper = reg_shadow[REG_IUPPER];
        lower = reg_shadow[REG_ILOWER];
        if (rq.restart) begin
            integ_state = '0;
            last_error  = '0;
        end
        e = rq.err;
        s = clip32(integ_state + e);
        if (s < lower)
            s = lower;
        else if (s > upper)
            s = upper;
        mag = (e < 0) ? -e : e;
        res.in_band = (mag < longint'(reg_shadow[REG_TOL][TOL_W-1:0]));
        if (res.in_band)
            s = 0;
        integ_state = s[INTEG_W-1:0];
        d = e - last_error;
        acc = kp * e + ki * s + kd * d;
        acc = clip32(acc / (longint'(1) << GAIN_FRAC_DEF));
        res.drive = res.in_band ? '0 : acc[DRIVE_W-1:0];
        last_error = rq.err;
        return res;
    endfunction

    // Mostly short idle spans, now and then a long one.
    function automatic int pick_idle(input t_idle_mode mode);
        int r;
        if (mode == IDLE_NONE)
            return 0;
        r = $urandom_range(99);
        if (r < ((mode == IDLE_LIGHT) ? 75 : 40))
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
        if (sel < 60)
            return 16'($urandom_range(0, 2048)) - 16'd1024;
        return 16'($urandom());
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       sel;
        int       v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            r.err = 16'(int'($urandom_range(0, 400)) - 200);
        end else if (sel < 80) begin
            r.err = 16'($urandom());
        end else if (sel < 88) begin
            r.err = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        end else begin
            // Right around the deadband edge.
            v = int'(reg_shadow[REG_TOL][TOL_W-1:0]) + int'($urandom_range(0, 4)) - 2;
            r.err = ($urandom_range(1) != 0) ? 16'(v) : 16'(-v);
        end
        r.restart     = ($urandom_range(99) < 4);
        r.drain_first = ($urandom_range(99) < 2);
        return r;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_drives.push_back(control_step(on_bus));
                n_requests++;
                if (on_bus.restart)
                    n_restarts++;
                if (expected_drives[$].in_band)
                    n_within++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() != 0 &&
                             !(pending_requests[0].drain_first && expected_drives.size() != 0)) begin
                    on_bus = pending_requests.pop_front();
                    i_valid   <= 1'b1;
                    i_error   <= on_bus.err;
                    i_restart <= on_bus.restart;
                    gap_left = pick_idle(gap_mode);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t: result with nothing expected: drive %0d within %0b",
                             $time, o_drive, o_within_tolerance);
                    failures++;
                end else begin
                    oldest = expected_drives.pop_front();
                    if (o_drive !== oldest.drive) begin
                        $display("%0t: drive mismatch: expected %0d, actual %0d",
                                 $time, oldest.drive, o_drive);
                        failures++;
                    end
                    if (o_within_tolerance !== oldest.in_band) begin
                        $display("%0t: within_tolerance mismatch: expected %0b, actual %0b",
                                 $time, oldest.in_band, o_within_tolerance);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_idle(stall_mode);
                i_stall <= (stall_left != 0);
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_drives.size());
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
        logic [CFG_DW-1:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        apply_reg(idx, val);
    endtask

    task automatic check_regs();
        logic [CFG_DW-1:0] rd;
        for (int i = REG_KP; i <= REG_TOL; i++) begin
            apb_xfer(1'b0, 3'(i), '0, rd);
            if ((rd & reg_mask(3'(i))) !== reg_shadow[i]) begin
                $display("%0t: register %0d readback: expected %h, actual %h",
                         $time, i, reg_shadow[i], rd & reg_mask(3'(i)));
                failures++;
            end
        end
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [INTEG_W-1:0] upper,
                              input logic [INTEG_W-1:0] lower, input logic [TOL_W-1:0] tol);
        write_reg(REG_KP, 32'(signed'(kp)));
        write_reg(REG_KI, 32'(signed'(ki)));
        write_reg(REG_KD, 32'(signed'(kd)));
        write_reg(REG_IUPPER, upper);
        write_reg(REG_ILOWER, lower);
        write_reg(REG_TOL, 32'(tol));
        n_settings++;
    endtask

    task automatic random_config();
        logic [INTEG_W-1:0] upper;
        logic [INTEG_W-1:0] lower;
        logic [TOL_W-1:0]   tol;
        int                 sel;
        sel = $urandom_range(99);
        if (sel < 55) begin
            upper = $urandom_range(0, 400000);
            lower = 0 - int'($urandom_range(0, 400000));
        end else if (sel < 70) begin
            // Crossed bounds: lower above upper.
            lower = int'($urandom_range(0, 5000)) - 2500;
            upper = lower - int'($urandom_range(1, 10000));
        end else if (sel < 85) begin
            upper = $urandom();
            lower = $urandom();
        end else begin
            upper = INT_MAX;
            lower = INT_MIN;
        end
        sel = $urandom_range(99);
        if (sel < 30)
            tol = '0;
        else if (sel < 80)
            tol = $urandom_range(1, 64);
        else if (sel < 90)
            tol = 16'd32768;
        else
            tol = $urandom_range(0, 32768);
        set_config(random_gain(), random_gain(), random_gain(), upper, lower, tol);
        check_regs();
    endtask

    task automatic queue_request(input logic signed [ERROR_WIDTH_DEF-1:0] err,
                                 input logic restart);
        t_request r;
        r.err         = err;
        r.restart     = restart;
        r.drain_first = 1'b0;
        pending_requests.push_back(r);
    endtask

    // Holds until every request has gone out and every result has come back.
    task automatic drain();
        while (pending_requests.size() != 0 || i_valid || expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        foreach (reg_shadow[i])
            reg_shadow[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_regs();

        // Reset settings: zero gains and zero tolerance give zero drive.
        gap_mode   = IDLE_LIGHT;
        stall_mode = IDLE_LIGHT;
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sh0000, 1'b1);
        drain();

        // Deadband edges and the upper integral clamp.
        set_config(16'sh0100, 16'sh0080, -16'sh0100, 32'sd50000, -32'sd50000, 16'd10);
        write_reg(REG_SPARE_LO, 32'hdead_beef);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        check_regs();
        queue_request(16'sd0, 1'b0);
        queue_request(16'sd9, 1'b0);
        queue_request(-16'sd9, 1'b0);
        queue_request(16'sd10, 1'b0);
        queue_request(-16'sd10, 1'b0);
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sd100, 1'b1);
        queue_request(16'sd1, 1'b0);
        queue_request(-16'sd1, 1'b0);
        drain();

        // The lower bound pins the integral near the top, so the sum saturates
        // and the largest gains push the drive past its positive limit.
        set_config(16'sh7fff, 16'sh7fff, 16'sh7fff, INT_MAX, INT_MAX - 5, 16'd0);
        check_regs();
        queue_request(16'sd1, 1'b0);
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sd0, 1'b1);
        drain();

        // Mirror image at the negative limit.
        set_config(16'sh8000, 16'sh8000, 16'sh8000, INT_MIN + 5, INT_MIN, 16'd0);
        check_regs();
        queue_request(-16'sd1, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sh7fff, 1'b0);
        drain();

        // Crossed bounds with a deadband of 32768, which takes in every error but -32768.
        set_config(16'sh0100, 16'sh0001, 16'sh0200, -32'sd1000, 32'sd1000, 16'd32768);
        check_regs();
        queue_request(16'sh7fff, 1'b0);
        queue_request(16'sh8000, 1'b0);
        queue_request(16'sd5, 1'b0);
        queue_request(16'sh8000, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            gap_mode   = t_idle_mode'(p % 3);
            stall_mode = t_idle_mode'((p + p / 3) % 3);
            repeat (PHASE_REQUESTS)
                pending_requests.push_back(random_request());
            drain();
        end

        $display("Ran %0d requests over %0d register settings: %0d restarts, %0d in the deadband.",
                 n_requests, n_settings, n_restarts, n_within);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches seen.", failures);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
